FILE: rtl/ahds_pkg.sv
`default_nettype none
package ahds_pkg;

    localparam int MAX_RANKS       = 64;
    localparam int MAX_PHASE_STEPS = 6;
    localparam int MAX_SLOTS       = 32;
    localparam int REM_ITERS       = 6;
    localparam int REM_CNT_W       = $clog2(REM_ITERS + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_RANK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MY_RANK    = 2'd1;

    typedef struct packed {
        logic [3:0] step;
        logic [3:0] total_steps;
    } ahds_in_t;

    typedef struct packed {
        logic [5:0] send_peer;
        logic [5:0] recv_peer;
        logic [5:0] slice_count;
        logic [5:0] tx_slice;
        logic [5:0] rx_slice;
        logic       phase;
        logic [2:0] phase_step;
        logic       slot_valid;
        logic       last;
    } ahds_out_t;

    typedef enum logic [1:0] {
        REM_ME,
        REM_STEP,
        REM_DIST
    } ahds_rem_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ME,
        ST_STEP,
        ST_DIST_GO,
        ST_DIST,
        ST_SETUP,
        ST_EMIT
    } ahds_state_t;

    typedef struct packed {
        logic          load;
        logic          rem_start;
        ahds_rem_sel_t rem_sel;
        logic          cap_me;
        logic          cap_step;
        logic          cap_dist;
        logic          setup;
        logic          advance;
    } ahds_cmd_t;

    typedef struct packed {
        logic rem_done;
        logic half_zero;
        logic out_last;
    } ahds_status_t;

endpackage
`default_nettype wire

FILE: rtl/ahds_rem.sv
`default_nettype none
module ahds_rem (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       start,
    input  wire logic [5:0] dividend,
    input  wire logic [6:0] divisor,
    output logic      [5:0] remainder,
    output logic            done
);
    import ahds_pkg::*;

    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [5:0]           quo_reg, quo_next;
    logic [5:0]           rem_reg, rem_next;
    logic [6:0]           trial;
    logic [6:0]           diff;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[5]};
        diff  = (trial >= divisor) ? (trial - divisor) : trial;
    end

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            cnt_next  = REM_CNT_W'(REM_ITERS);
            done_next = 1'b0;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[4:0], 1'b0};
            rem_next = diff[5:0];
            if (cnt_reg == REM_CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule
`default_nettype wire

FILE: rtl/ahds_dp.sv
`default_nettype none
module ahds_dp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [ahds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ahds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire ahds_pkg::ahds_in_t               s_data,
    input  wire ahds_pkg::ahds_cmd_t              cmd,
    output ahds_pkg::ahds_status_t                status,
    output ahds_pkg::ahds_out_t                   m_data
);
    import ahds_pkg::*;

    logic [6:0] rank_count_reg;
    logic [5:0] my_rank_reg;
    logic [3:0] step_reg;
    logic [2:0] half_reg, half_next;
    logic [5:0] me_reg;
    logic       ph_reg, ph_next;
    logic [2:0] s_reg, s_next;
    logic [2:0] e_reg, e_next;
    logic [5:0] dist_reg;
    logic [5:0] dm_reg;
    logic [5:0] ds_reg, ds_next;
    logic [5:0] remain_reg;
    ahds_out_t  out_reg, out_next;

    logic [6:0] rs;
    logic [5:0] rem_dividend;
    logic [6:0] rem_divisor;
    logic [5:0] rem_result;
    logic       rem_done;

    logic [5:0] me_sub, me_add;
    logic [6:0] ds2;
    logic [6:0] cnt_sum, cnt_full;
    logic [5:0] cnt;
    logic [5:0] tx_adv, rx_adv;

    // (v mod n) for v below 2n
    function automatic logic [5:0] wrap(input logic [7:0] v, input logic [6:0] n);
        logic [7:0] r;
        r = (v >= {1'b0, n}) ? (v - {1'b0, n}) : v;
        return r[5:0];
    endfunction

    always_comb begin
        if (rank_count_reg == '0) begin
            rs = 7'd1;
        end else if (rank_count_reg > 7'(MAX_RANKS)) begin
            rs = 7'(MAX_RANKS);
        end else begin
            rs = rank_count_reg;
        end
    end

    always_comb begin
        case (cmd.rem_sel)
            REM_ME: begin
                rem_dividend = my_rank_reg;
                rem_divisor  = rs;
            end
            REM_STEP: begin
                rem_dividend = {2'b00, step_reg};
                rem_divisor  = {4'b0000, half_reg};
            end
            REM_DIST: begin
                rem_dividend = dist_reg;
                rem_divisor  = rs;
            end
            default: begin
                rem_dividend = my_rank_reg;
                rem_divisor  = rs;
            end
        endcase
    end

    ahds_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (rem_dividend),
        .divisor   (rem_divisor),
        .remainder (rem_result),
        .done      (rem_done)
    );

    always_comb begin
        half_next = (s_data.total_steps[3:1] > 3'(MAX_PHASE_STEPS))
                  ? 3'(MAX_PHASE_STEPS) : s_data.total_steps[3:1];
    end

    // phase, step within phase and log2 of the distance
    always_comb begin
        ph_next = ({1'b0, step_reg} >= {2'b00, half_reg});
        s_next  = ph_next ? rem_result[2:0] : step_reg[2:0];
        e_next  = ph_next ? (half_reg - 3'd1 - s_next) : s_next;
    end

    always_comb begin
        me_sub   = wrap({2'b00, me_reg} + {1'b0, rs} - {2'b00, dm_reg}, rs);
        me_add   = wrap({2'b00, me_reg} + {2'b00, dm_reg}, rs);
        ds2      = {dm_reg, 1'b0};
        ds_next  = wrap({1'b0, ds2}, rs);
        cnt_sum  = rs - 7'd1 + {1'b0, dist_reg};
        cnt_full = cnt_sum >> (e_reg + 3'd1);
        cnt      = cnt_full[5:0];
        tx_adv   = wrap({2'b00, out_reg.tx_slice} + {1'b0, rs} - {2'b00, ds_reg}, rs);
        rx_adv   = wrap({2'b00, out_reg.rx_slice} + {1'b0, rs} - {2'b00, ds_reg}, rs);
    end

    always_comb begin
        out_next = out_reg;
        if (cmd.setup) begin
            if (half_reg == '0) begin
                out_next.send_peer   = me_reg;
                out_next.recv_peer   = me_reg;
                out_next.slice_count = '0;
                out_next.tx_slice    = '0;
                out_next.rx_slice    = '0;
                out_next.phase       = 1'b0;
                out_next.phase_step  = '0;
                out_next.slot_valid  = 1'b0;
                out_next.last        = 1'b1;
            end else begin
                out_next.send_peer   = ph_reg ? me_add : me_sub;
                out_next.recv_peer   = ph_reg ? me_sub : me_add;
                out_next.slice_count = cnt;
                out_next.phase       = ph_reg;
                out_next.phase_step  = s_reg;
                out_next.slot_valid  = (cnt != '0);
                out_next.last        = (cnt <= 6'd1);
                if (cnt == '0) begin
                    out_next.tx_slice = '0;
                    out_next.rx_slice = '0;
                end else begin
                    out_next.tx_slice = ph_reg ? me_reg : me_sub;
                    out_next.rx_slice = ph_reg ? me_sub : me_reg;
                end
            end
        end else if (cmd.advance && !out_reg.last) begin
            out_next.tx_slice = tx_adv;
            out_next.rx_slice = rx_adv;
            out_next.last     = (remain_reg == 6'd2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_count_reg <= 7'd1;
            my_rank_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RANK_COUNT: rank_count_reg <= cfg_data;
                CFG_MY_RANK:    my_rank_reg    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            step_reg <= s_data.step;
            half_reg <= half_next;
        end
        if (cmd.cap_me) begin
            me_reg <= rem_result;
        end
        if (cmd.cap_step) begin
            ph_reg   <= ph_next;
            s_reg    <= s_next;
            e_reg    <= e_next;
            dist_reg <= 6'd1 << e_next;
        end
        if (cmd.cap_dist) begin
            dm_reg <= rem_result;
        end
        if (cmd.setup) begin
            ds_reg     <= ds_next;
            remain_reg <= cnt;
        end else if (cmd.advance) begin
            remain_reg <= remain_reg - 6'd1;
        end
        out_reg <= out_next;
    end

    assign status.rem_done  = rem_done;
    assign status.half_zero = (half_reg == '0);
    assign status.out_last  = out_reg.last;
    assign m_data           = out_reg;

    a_me_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_me |=> (me_reg < rs))
        else $error("own position not reduced below rank count");

    a_dm_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_dist |=> (dm_reg < rs))
        else $error("distance not reduced below rank count");

    a_slot_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.advance && !out_reg.last) |=> (out_reg.slot_valid && remain_reg != '0))
        else $error("slot run ended without a last word");

endmodule
`default_nettype wire

FILE: rtl/ahds_ctrl.sv
`default_nettype none
module ahds_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire ahds_pkg::ahds_status_t status,
    output ahds_pkg::ahds_cmd_t         cmd
);
    import ahds_pkg::*;

    ahds_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_ME;
            ST_ME: begin
                if (status.rem_done) begin
                    state_next = status.half_zero ? ST_SETUP : ST_STEP;
                end
            end
            ST_STEP:    if (status.rem_done) state_next = ST_DIST_GO;
            ST_DIST_GO: state_next = ST_DIST;
            ST_DIST:    if (status.rem_done) state_next = ST_SETUP;
            ST_SETUP:   state_next = ST_EMIT;
            ST_EMIT:    if (m_ready && status.out_last) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.rem_sel = REM_ME;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    cmd.rem_start = 1'b1;
                end
            end
            ST_ME: begin
                if (status.rem_done) begin
                    cmd.cap_me = 1'b1;
                    if (!status.half_zero) begin
                        cmd.rem_start = 1'b1;
                        cmd.rem_sel   = REM_STEP;
                    end
                end
            end
            ST_STEP: begin
                cmd.rem_sel  = REM_STEP;
                cmd.cap_step = status.rem_done;
            end
            ST_DIST_GO: begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = REM_DIST;
            end
            ST_DIST: begin
                cmd.rem_sel  = REM_DIST;
                cmd.cap_dist = status.rem_done;
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
            end
            ST_EMIT: begin
                m_valid     = 1'b1;
                cmd.advance = m_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new word taken while a step is in progress");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && status.out_last) |=> (state_reg == ST_IDLE))
        else $error("last word did not end the step");

    a_setup_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.setup |=> m_valid)
        else $error("setup not followed by output");

endmodule
`default_nettype wire

FILE: rtl/allreduce_halving_doubling_step_schedule.sv
// Result words: after an input word is accepted, one result word per cycle while
// m_ready is high, up to the word marked last.
// Throughput: one step at a time; a new input word is taken only after the last
// result word of the step, and each step first runs three remainder passes
// through one shared divider (one pass when total_steps is below 2).
// Reset (aresetn low, synchronous): rank_count 1, my_rank 0, controller idle.
`default_nettype none
module allreduce_halving_doubling_step_schedule (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ahds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ahds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire ahds_pkg::ahds_in_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output ahds_pkg::ahds_out_t                   m_data
);
    import ahds_pkg::*;

    ahds_cmd_t    cmd;
    ahds_status_t status;

    assign cfg_ready = 1'b1;

    ahds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ahds_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

FILE: verif/ahds_schedule_checker.sv
`timescale 1ns / 1ps
module ahds_schedule_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [ahds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ahds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire ahds_pkg::ahds_in_t               s_data,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  wire ahds_pkg::ahds_out_t              m_data,
    output int                                    n_fail,
    output int                                    n_pending
);
    import ahds_pkg::*;

    logic [6:0] rank_cnt;
    logic [5:0] own_rank;
    ahds_out_t  slot_q[$];
    int         fails;

    function automatic int unsigned sub_mod(int unsigned a, int unsigned d, int unsigned n);
        return (a + n - (d % n)) % n;
    endfunction

    function automatic void schedule_step(ahds_in_t w);
        int unsigned rs, me, half, s, span, dslice, cnt, sp, rp, tx, rx, n, i;
        logic        ph;
        ahds_out_t   r;
        rs = rank_cnt;
        if (rs == 0) rs = 1;
        if (rs > MAX_RANKS) rs = MAX_RANKS;
        me = own_rank % rs;
        half = w.total_steps / 2;
        if (half > MAX_PHASE_STEPS) half = MAX_PHASE_STEPS;
        span = 1;
        tx = 0;
        rx = 0;
        if (half == 0) begin
            sp = me;
            rp = me;
            ph = 1'b0;
            s = 0;
            cnt = 0;
        end else begin
            if (w.step < half) begin
                ph = 1'b0;
                s = w.step;
                span = 1 << s;
                sp = sub_mod(me, span, rs);
                rp = (me + span % rs) % rs;
                tx = sp;
                rx = me;
            end else begin
                ph = 1'b1;
                s = w.step % half;
                span = 1 << (half - 1 - s);
                rp = sub_mod(me, span, rs);
                sp = (me + span % rs) % rs;
                tx = me;
                rx = rp;
            end
            cnt = (rs - 1 + span) / (span << 1);
        end
        dslice = span << 1;
        r.send_peer   = sp[5:0];
        r.recv_peer   = rp[5:0];
        r.slice_count = cnt[5:0];
        r.phase       = ph;
        r.phase_step  = s[2:0];
        if (cnt == 0) begin
            r.tx_slice   = '0;
            r.rx_slice   = '0;
            r.slot_valid = 1'b0;
            r.last       = 1'b1;
            slot_q = {slot_q, r};
        end else begin
            n = (cnt > MAX_SLOTS) ? MAX_SLOTS : cnt;
            for (i = 0; i < n; i++) begin
                r.tx_slice   = tx[5:0];
                r.rx_slice   = rx[5:0];
                r.slot_valid = 1'b1;
                r.last       = (i + 1 == n);
                slot_q = {slot_q, r};
                tx = sub_mod(tx, dslice, rs);
                rx = sub_mod(rx, dslice, rs);
            end
        end
    endfunction

    always @(posedge aclk) begin
        ahds_out_t e;
        if (!aresetn) begin
            rank_cnt = 7'd1;
            own_rank = 6'd0;
            slot_q.delete();
            fails = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RANK_COUNT: rank_cnt = cfg_data;
                    CFG_MY_RANK:    own_rank = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) schedule_step(s_data);
            if (m_valid && m_ready) begin
                if (slot_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word %h at %0t", m_data, $time);
                end else begin
                    e = slot_q.pop_front();
                    if (m_data.send_peer !== e.send_peer || m_data.recv_peer !== e.recv_peer ||
                        m_data.slice_count !== e.slice_count ||
                        m_data.tx_slice !== e.tx_slice || m_data.rx_slice !== e.rx_slice ||
                        m_data.phase !== e.phase || m_data.phase_step !== e.phase_step ||
                        m_data.slot_valid !== e.slot_valid || m_data.last !== e.last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch at %0t", $time);
                            $display("  exp sp=%0d rp=%0d cnt=%0d tx=%0d rx=%0d ph=%0d ps=%0d v=%0d l=%0d",
                                     e.send_peer, e.recv_peer, e.slice_count, e.tx_slice,
                                     e.rx_slice, e.phase, e.phase_step, e.slot_valid, e.last);
                            $display("  got sp=%0d rp=%0d cnt=%0d tx=%0d rx=%0d ph=%0d ps=%0d v=%0d l=%0d",
                                     m_data.send_peer, m_data.recv_peer, m_data.slice_count,
                                     m_data.tx_slice, m_data.rx_slice, m_data.phase,
                                     m_data.phase_step, m_data.slot_valid, m_data.last);
                        end
                    end
                end
            end
        end
        n_fail    <= fails;
        n_pending <= slot_q.size();
    end

endmodule

FILE: verif/allreduce_halving_doubling_step_schedule_tb.sv
`timescale 1ns / 1ps
module allreduce_halving_doubling_step_schedule_tb;
    import ahds_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    ahds_in_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    ahds_out_t              m_data;
    int                     n_fail;
    int                     n_pending;

    bit no_idle;
    int hold_req;

    allreduce_halving_doubling_step_schedule u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ahds_schedule_checker u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin
        int hold_done;
        hold_done = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_done) begin
                m_ready <= 1'b0;
                repeat (399) @(negedge aclk);
                hold_done++;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_step(input logic [3:0] st, input logic [3:0] tot);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= '{step: st, total_steps: tot};
        do @(posedge aclk); while (!s_ready);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge aclk);
        end
    endtask

    task automatic send_random(input int count);
        int          k;
        int unsigned h;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_step(4'($urandom), 4'($urandom));
            end else begin
                h = $urandom_range(1, 6);
                send_step(4'($urandom_range(0, 2 * h - 1)),
                          4'(2 * h + $urandom_range(0, 1)));
            end
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ranks(input logic [6:0] rc, input logic [6:0] mr);
        drain();
        repeat (30) @(negedge aclk);
        cfg_write(CFG_RANK_COUNT, rc);
        cfg_write(CFG_MY_RANK, mr);
    endtask

    initial begin
        int p;
        logic [6:0] rc_list[8];
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        no_idle   = 1'b0;
        hold_req  = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset configuration
        send_step(4'd0, 4'd4);
        // typical group
        set_ranks(7'd8, 7'd3);
        send_step(4'd0, 4'd0);
        send_step(4'd0, 4'd1);
        send_step(4'd0, 4'd2);
        send_step(4'd1, 4'd2);
        send_step(4'd0, 4'd12);
        send_step(4'd5, 4'd12);
        send_step(4'd6, 4'd12);
        send_step(4'd11, 4'd12);
        send_step(4'd15, 4'd15);
        send_step(4'd3, 4'd14);
        // zero rank count, own rank out of range
        set_ranks(7'd0, 7'd5);
        send_step(4'd0, 4'd4);
        // saturated rank count, top bit of data set
        set_ranks(7'd127, 7'd127);
        send_step(4'd0, 4'd12);
        send_step(4'd5, 4'd12);
        send_step(4'd7, 4'd12);
        // distance beyond the group: empty step
        set_ranks(7'd2, 7'd1);
        send_step(4'd5, 4'd12);
        send_step(4'd0, 4'd12);
        drain();
        repeat (30) @(negedge aclk);
        cfg_write(CFG_SPARE_A, 7'h55);
        cfg_write(CFG_SPARE_B, 7'h2a);
        send_step(4'd1, 4'd4);

        // back pressure until the input stalls
        set_ranks(7'd64, 7'd17);
        hold_req++;
        send_random(12);
        drain();

        rc_list[0] = 7'd64;
        rc_list[1] = 7'd1;
        rc_list[2] = 7'd0;
        rc_list[3] = 7'd127;
        rc_list[4] = 7'd2;
        rc_list[5] = 7'($urandom_range(3, 63));
        rc_list[6] = 7'($urandom_range(65, 126));
        rc_list[7] = 7'($urandom_range(3, 64));
        for (p = 0; p < 8; p++) begin
            set_ranks(rc_list[p], 7'($urandom_range(0, 127)));
            if (p == 7) no_idle = 1'b1;
            send_random(50);
        end

        drain();
        repeat (40) @(posedge aclk);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
